@@ src/sets_pkg.sv @@
// shared constants and word types for the scope edge trigger search unit
package sets_pkg;

  localparam int MAX_FRAMES     = 4096;
  localparam int ADDR_W         = $clog2(MAX_FRAMES);
  localparam int CNT_W          = $clog2(MAX_FRAMES + 1);
  localparam int SAMPLE_W       = 16;
  localparam int OFFSET_W       = 13;
  localparam int MIN_PEAK_W     = 15;
  localparam logic [MIN_PEAK_W-1:0] MIN_PEAK_RESET = MIN_PEAK_W'(33);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
  } in_word_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                found;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan;
    logic emit;
  } sets_cmd_t;

  typedef struct packed {
    logic qualify;
    logic scan_done;
    logic out_full;
  } sets_status_t;

endpackage

@@ src/sets_ram.sv @@
// generic single write port ram with registered read
module sets_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sets_ctrl.sv @@
// controller state machine for load, scan and result hand-off
module sets_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic                  out_ready,
  output logic                  in_ready,
  output sets_pkg::sets_cmd_t    cmd,
  input  sets_pkg::sets_status_t status
);
  import sets_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load      = accept;
    case (state)
      S_LOAD: begin
        if (accept && in_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_init = 1'b1;
        state_next    = status.qualify ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.out_full || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/sets_dp.sv @@
// datapath: sample store, peak tracker, rescan and result register
module sets_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  sets_pkg::in_word_t              in_word,
  input  logic                            cfg_we,
  input  logic [sets_pkg::MIN_PEAK_W-1:0] cfg_wdata,
  input  logic                            out_ready,
  output logic                            out_valid,
  output sets_pkg::out_word_t             out_word,
  input  sets_pkg::sets_cmd_t             cmd,
  output sets_pkg::sets_status_t          status
);
  import sets_pkg::*;

  logic [MIN_PEAK_W-1:0] min_peak;
  logic [CNT_W-1:0]      count;
  logic [SAMPLE_W-1:0]   peak;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      idx_d;
  logic                  rd_valid;
  logic                  armed;
  logic                  hit;
  logic [CNT_W-1:0]      result;

  logic                       store_we;
  logic [SAMPLE_W-1:0]        mag;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W+1:0] v4;
  logic signed [SAMPLE_W+1:0] neg_peak;

  assign store_we = cmd.load && (count < CNT_W'(MAX_FRAMES));
  assign mag      = in_word.sample[SAMPLE_W-1] ? (~in_word.sample + 1'b1) : in_word.sample;
  assign v4       = {rdata, 2'b00};
  assign neg_peak = -$signed({2'b00, peak});

  assign status.qualify   = (count >= CNT_W'(2)) && (peak >= {1'b0, min_peak});
  assign status.scan_done = (idx == count) && !rd_valid;
  assign status.out_full  = out_valid;

  sets_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_FRAMES)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(in_word.sample),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(rdata)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_peak <= MIN_PEAK_RESET;
    end else if (cfg_we) begin
      min_peak <= cfg_wdata;
    end
  end

  // window fill and peak
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      peak  <= '0;
    end else if (cmd.emit) begin
      count <= '0;
      peak  <= '0;
    end else if (store_we) begin
      count <= count + 1'b1;
      if (mag > peak) begin
        peak <= mag;
      end
    end
  end

  // rescan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      idx      <= '0;
    end else if (cmd.scan_init) begin
      rd_valid <= 1'b0;
      idx      <= '0;
    end else if (cmd.scan && (idx != count)) begin
      rd_valid <= 1'b1;
      idx      <= idx + 1'b1;
    end else begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= idx;
    if (cmd.scan_init) begin
      result <= count;
      hit    <= 1'b0;
      armed  <= 1'b0;
    end else if (rd_valid) begin
      if (v4 < neg_peak) begin
        armed <= 1'b1;
      end else if (armed && !rdata[SAMPLE_W-1]) begin
        result <= idx_d;
        hit    <= 1'b1;
        armed  <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.offset <= OFFSET_W'(result);
      out_word.found  <= hit;
    end
  end

endmodule

@@ src/scope_edge_trigger_search_unit.sv @@
// top level of the scope edge trigger search unit
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    sample, is_last
//   out      output     out_valid / out_ready  offset, found
//   cfg      input      cfg_we                 min_peak
//
// samples load at one per cycle into the 4096-entry sample ram
// the word with is_last leads to a check step, then, if the window qualifies, a rescan
// through the ram read port, then a finish step that loads the result register
// rst clears fill count, peak and control and sets min_peak to its reset value; the ram needs no clearing
// a held result stalls only the finish step; the next window loads once it is taken
module scope_edge_trigger_search_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sets_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sets_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [sets_pkg::MIN_PEAK_W-1:0] cfg_wdata
);
  import sets_pkg::*;

  sets_cmd_t    cmd;
  sets_status_t status;

  sets_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_word.is_last),
    .out_ready(out_ready),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  sets_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_word (out_word),
    .cmd      (cmd),
    .status   (status)
  );

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_word.is_last) |=> !in_ready)
    else $error("input still open after last word");

  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word appeared while loading");

  a_found_not_first: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.found) |-> (out_word.offset != '0))
    else $error("edge reported at first sample");

endmodule

@@ tb/tb_top.sv @@
// testbench for the scope edge trigger search unit: directed and random windows
`timescale 1ns / 1ps

module tb_top;
  import sets_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_PAD       = 8;
  localparam int PHASE_ITEMS    = 100;

  typedef enum int {WAVE_EDGE, WAVE_NOISE, WAVE_QUIET} wave_kind_e;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [MIN_PEAK_W-1:0] cfg_wdata = '0;

  scope_edge_trigger_search_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block state
  logic signed [SAMPLE_W-1:0] win_store [0:MAX_FRAMES-1];
  int unsigned                win_len  = 0;
  int unsigned                win_peak = 0;
  logic [MIN_PEAK_W-1:0]      min_peak_shadow = MIN_PEAK_RESET;

  out_word_t pending_triggers [$];
  out_word_t want;
  int        seq [$];

  bit no_stall     = 1'b0;
  int errors       = 0;
  int n_samples    = 0;
  int n_windows    = 0;
  int n_found      = 0;
  int n_cfg        = 0;
  int idle_cycles  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // store each accepted sample; run the trigger search when the window closes
  function automatic void capture_sample(in_word_t w);
    int v;
    int neg_peak;
    int unsigned mag;
    int unsigned idx;
    bit armed;
    bit hit;
    out_word_t res;
    v = w.sample;
    if (win_len < MAX_FRAMES) begin
      mag = (v < 0) ? -v : v;
      win_store[win_len] = w.sample;
      win_len++;
      if (mag > win_peak) win_peak = mag;
    end
    n_samples++;
    if (!w.is_last) return;
    idx = win_len;
    hit = 1'b0;
    if (win_len >= 2 && win_peak >= min_peak_shadow) begin
      neg_peak = -int'(win_peak);
      armed = 1'b0;
      for (int i = 0; i < int'(win_len); i++) begin
        v = win_store[i];
        if (v * 4 < neg_peak) begin
          armed = 1'b1;
        end else if (armed && v >= 0) begin
          idx = i;
          hit = 1'b1;
          armed = 1'b0;
        end
      end
    end
    res.offset = OFFSET_W'(idx);
    res.found  = hit;
    pending_triggers.push_back(res);
    n_windows++;
    if (hit) n_found++;
    win_len  = 0;
    win_peak = 0;
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) capture_sample(in_word);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_triggers.size() == 0) begin
        $error("unexpected result word: offset %0d found %0d", out_word.offset, out_word.found);
        errors++;
      end else begin
        want = pending_triggers.pop_front();
        if (out_word.offset !== want.offset) begin
          $error("offset mismatch: expected %0d, got %0d", want.offset, out_word.offset);
          errors++;
        end
        if (out_word.found !== want.found) begin
          $error("found mismatch: expected %0d, got %0d", want.found, out_word.found);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int on_len;
    int off_len;
    @(posedge clk);
    forever begin
      if (no_stall) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        on_len = $urandom_range(1, 12);
        out_ready <= 1'b1;
        repeat (on_len) @(posedge clk);
        off_len = idle_len();
        if (off_len > 0) begin
          out_ready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_stall ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_seq();
    in_word_t w;
    for (int i = 0; i < seq.size(); i++) begin
      w.sample  = SAMPLE_W'(seq[i]);
      w.is_last = (i == seq.size() - 1);
      send_word(w);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_triggers.size() > 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_min_peak(input logic [MIN_PEAK_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_peak_shadow = v;
    n_cfg++;
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_sample(wave_kind_e kind, int p);
    int r;
    int m;
    case (kind)
      WAVE_NOISE: begin
        return int'($signed(16'($urandom_range(0, 65535))));
      end
      WAVE_QUIET: begin
        m = min_peak_shadow;
        return clamp16(int'($urandom_range(0, 2 * m + 2)) - (m + 1));
      end
      default: begin
        r = $urandom_range(0, 9);
        if (r < 3) return clamp16(-int'($urandom_range(p / 4, p)));
        if (r < 6) return clamp16(int'($urandom_range(0, p)));
        if (r < 8) return clamp16(-(p / 4) + int'($urandom_range(0, 4)) - 2);
        return int'($urandom_range(0, 6)) - 3;
      end
    endcase
  endfunction

  task automatic send_window(input int len, input wave_kind_e kind, input int p);
    int peak_at;
    int s;
    in_word_t w;
    peak_at = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if (kind == WAVE_EDGE && i == peak_at) s = $urandom_range(0, 1) ? clamp16(p) : -p;
      else s = pick_sample(kind, p);
      w.sample  = SAMPLE_W'(s);
      w.is_last = (i == len - 1);
      send_word(w);
    end
  endtask

  task automatic test_short_windows();
    seq = {-32768};
    send_seq();
    seq = {-32768, 32767};
    send_seq();
    seq = {0};
    send_seq();
  endtask

  task automatic test_edge_rules();
    seq = {-100, 50, -100, 50, 10};
    send_seq();
    seq = {100, -25, 0};
    send_seq();
    seq = {100, -26, 0};
    send_seq();
    seq = {32767, -1, 0};
    send_seq();
  endtask

  task automatic test_silence_threshold();
    seq = {-8, 8};
    send_seq();
    seq = {-33, 0};
    send_seq();
    seq = {-32, 0};
    send_seq();
  endtask

  task automatic test_min_peak_extremes();
    wait_idle();
    write_min_peak('0);
    seq = {0, 0};
    send_seq();
    wait_idle();
    write_min_peak('1);
    seq = {-32767, 0};
    send_seq();
    seq = {-32766, 0};
    send_seq();
  endtask

  task automatic test_random_windows();
    int sent;
    int len;
    int r;
    int p;
    wave_kind_e kind;
    logic [MIN_PEAK_W-1:0] mp;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       mp = MIN_PEAK_W'($urandom_range(0, 32767));
        1:       mp = MIN_PEAK_W'($urandom_range(0, 64));
        2:       mp = MIN_PEAK_RESET;
        default: mp = MIN_PEAK_W'($urandom_range(100, 2000));
      endcase
      write_min_peak(mp);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 10) len = $urandom_range(1, 2);
        else if (r < 85) len = $urandom_range(3, 40);
        else len = $urandom_range(41, 200);
        r = $urandom_range(0, 99);
        if (r < 60) kind = WAVE_EDGE;
        else if (r < 80) kind = WAVE_NOISE;
        else kind = WAVE_QUIET;
        r = $urandom_range(0, 9);
        if (r < 4) p = $urandom_range(1, 32768);
        else if (r < 7) p = int'(min_peak_shadow) + int'($urandom_range(0, 4)) - 2;
        else p = $urandom_range(1, 2000);
        if (p < 1) p = 1;
        no_stall = ($urandom_range(0, 99) < 15);
        send_window(len, kind, p);
        sent += len;
      end
      no_stall = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_short_windows();
    test_edge_rules();
    test_silence_threshold();
    test_min_peak_extremes();
    test_random_windows();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d windows from %0d sample words, %0d with a trigger edge",
             n_windows, n_samples, n_found);
    $display("min_peak written %0d times, including both ends of its range", n_cfg);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sets_pkg.sv
src/sets_ram.sv
src/sets_ctrl.sv
src/sets_dp.sv
src/scope_edge_trigger_search_unit.sv
tb/tb_top.sv
